@@ rtl/core/hkrp_pkg.sv @@
// ----------------------------------------------------------------------------
// hkrp_pkg
// shared constants, types and character helpers for the hex key record parser
// ----------------------------------------------------------------------------
package hkrp_pkg;

  localparam int MAX_KEYS_DEF    = 8;
  localparam int KEY_BYTES_DEF   = 32;
  localparam int ID_CAPACITY_DEF = 32;

  localparam int WORD_BYTES   = 8;
  localparam int WORD_W       = 8 * WORD_BYTES;
  localparam int REPORT_BYTES = 32;
  localparam int MEM_WORDS    = 8;
  localparam int MEM_AW       = 3;
  localparam int LANE_W       = 3;
  localparam int POS_W        = 7;

  localparam logic [MEM_AW-1:0] LAST_WORD = 3'd7;

  localparam logic ITEM_RECORD  = 1'b0;
  localparam logic ITEM_SUMMARY = 1'b1;

  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_F_LO = 8'h66;
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_F_UP = 8'h46;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [LANE_W-1:0] lane;
    logic [7:0]        data;
  } wr_req_t;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[CH_0:CH_9]}) begin
      d = c - CH_0;
    end else if (c inside {[CH_A_LO:CH_F_LO]}) begin
      d = c - CH_A_LO + HEX_ALPHA_BASE;
    end else if (c inside {[CH_A_UP:CH_F_UP]}) begin
      d = c - CH_A_UP + HEX_ALPHA_BASE;
    end
    return d[3:0];
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c inside {CH_SP, CH_TAB});
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c inside {CH_LF, CH_CR});
  endfunction

endpackage

@@ rtl/core/hkrp_store.sv @@
// ----------------------------------------------------------------------------
// hkrp_store
// record memory: identifier words then key words, byte writes, registered read
// ----------------------------------------------------------------------------
module hkrp_store (
  input  logic                                clk,
  input  hkrp_pkg::wr_req_t                   wr,
  input  logic                                rd_en,
  input  logic [hkrp_pkg::MEM_AW-1:0]         rd_addr,
  output logic [hkrp_pkg::WORD_W-1:0]         rd_data
);

  logic [hkrp_pkg::WORD_W-1:0] mem [hkrp_pkg::MEM_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr][{wr.lane, 3'b000} +: 8] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/hex_key_record_parser.sv @@
// ----------------------------------------------------------------------------
// hex_key_record_parser
// parses a text key database into identifier and key record words
// ----------------------------------------------------------------------------
// One text byte is taken per clock while the input is not held. A byte that
// completes a key holds the input while the four identifier words and four
// key words are read out of the record memory through its single read port,
// one word a cycle, and for the summary too when that byte is the end byte.
// An end byte that completes no key holds the input while the summary is
// issued. Output stalls lengthen these holds. Results leave through an
// output register, so the input keeps running while a finished word waits.
// ----------------------------------------------------------------------------
module hex_key_record_parser #(
  parameter int MAX_KEYS    = hkrp_pkg::MAX_KEYS_DEF,
  parameter int KEY_BYTES   = hkrp_pkg::KEY_BYTES_DEF,
  parameter int ID_CAPACITY = hkrp_pkg::ID_CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  text_byte,
  input  logic                        end_of_text,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        item_kind,
  output logic [2:0]                  slot,
  output logic [2:0]                  word_index,
  output logic [hkrp_pkg::WORD_W-1:0] word_value,
  output logic [4:0]                  id_length,
  output logic [3:0]                  key_total,
  output logic                        last_of_run
);

  localparam int IDW = $clog2(ID_CAPACITY);
  localparam int HXW = $clog2(2 * KEY_BYTES);
  localparam int PW  = hkrp_pkg::POS_W;

  localparam logic [IDW-1:0] ID_LIMIT    = IDW'(ID_CAPACITY - 1);
  localparam logic [HXW-1:0] HEX_LAST    = HXW'(2 * KEY_BYTES - 1);
  localparam logic [3:0]     KEY_LIMIT   = 4'(MAX_KEYS);
  localparam logic [PW-1:0]  KEY_BYTES_P = PW'(KEY_BYTES);
  localparam logic [PW-1:0]  REPORT_P    = PW'(hkrp_pkg::REPORT_BYTES);
  localparam logic [PW-1:0]  IDLEN_MAX   = PW'(31);

  localparam logic [2:0] PH_LINE_START = 3'd0;
  localparam logic [2:0] PH_IDENT      = 3'd1;
  localparam logic [2:0] PH_SEPARATOR  = 3'd2;
  localparam logic [2:0] PH_KEY        = 3'd3;
  localparam logic [2:0] PH_SKIP_LINE  = 3'd4;
  localparam logic [2:0] PH_STOPPED    = 3'd5;

  typedef struct packed {
    logic                          kind;
    logic [2:0]                    slot;
    logic [hkrp_pkg::MEM_AW-1:0]   widx;
    logic [PW-1:0]                 idcnt;
    logic [4:0]                    idlen;
    logic [3:0]                    total;
    logic                          last;
  } meta_t;

  // parser state
  logic [2:0]     phase, phase_next;
  logic [IDW-1:0] id_count, id_count_next;
  logic [HXW-1:0] hex_count, hex_count_next;
  logic [3:0]     pending, pending_next;
  logic [3:0]     accepted, accepted_next;

  // readout sequencer
  logic                        seq_busy;
  logic                        seq_record;
  logic                        seq_summary;
  logic [hkrp_pkg::MEM_AW-1:0] seq_word;
  logic [2:0]                  seq_slot;
  logic [PW-1:0]               seq_idcnt;
  logic [4:0]                  seq_idlen;
  logic [3:0]                  seq_total;
  logic [3:0]                  sum_total;

  logic                        s1_valid;
  meta_t                       s1;
  meta_t                       s1_next;

  hkrp_pkg::wr_req_t           wr;
  logic                        rd_en;
  logic [hkrp_pkg::WORD_W-1:0] rd_data;
  logic [hkrp_pkg::WORD_W-1:0] masked;

  logic          accept;
  logic          key_step;
  logic          rec_done;
  logic [3:0]    nib;
  logic [3:0]    acc_inc;
  logic [PW-1:0] id_pos;
  logic [PW-1:0] key_pos;
  logic [PW-1:0] id_cnt_p;
  logic          s2_load;
  logic          s1_free;
  logic          issue;

  assign accept   = in_valid && !in_stall;
  assign in_stall = seq_busy;
  assign nib      = hkrp_pkg::nibble_of(text_byte);
  assign acc_inc  = accepted + 4'd1;
  assign id_cnt_p = PW'(id_count);
  assign key_pos  = PW'(hex_count >> 1);

  always_comb begin
    phase_next     = phase;
    id_count_next  = id_count;
    hex_count_next = hex_count;
    pending_next   = pending;
    accepted_next  = accepted;
    key_step       = 1'b0;
    rec_done       = 1'b0;
    id_pos         = '0;
    wr             = '0;

    if (phase != PH_STOPPED) begin
      if (hkrp_pkg::is_eol(text_byte)) begin
        phase_next = PH_LINE_START;
      end else begin
        case (phase)
          PH_LINE_START: begin
            id_count_next  = '0;
            hex_count_next = '0;
            if (hkrp_pkg::is_blank(text_byte)) begin
              phase_next = PH_SEPARATOR;
            end else begin
              wr.en         = 1'b1;
              id_count_next = IDW'(1);
              phase_next    = PH_IDENT;
            end
          end
          PH_IDENT: begin
            if (hkrp_pkg::is_blank(text_byte)) begin
              phase_next = PH_SEPARATOR;
            end else if (id_count < ID_LIMIT) begin
              id_pos        = id_cnt_p;
              wr.en         = id_cnt_p < REPORT_P;
              id_count_next = id_count + IDW'(1);
            end
          end
          PH_SEPARATOR: begin
            if (!hkrp_pkg::is_blank(text_byte)) begin
              phase_next = PH_KEY;
              key_step   = 1'b1;
            end
          end
          PH_KEY: begin
            key_step = 1'b1;
          end
          PH_SKIP_LINE: begin
          end
          default: begin
            phase_next = PH_STOPPED;
          end
        endcase
      end
    end

    wr.addr = {1'b0, id_pos[4:3]};
    wr.lane = id_pos[2:0];
    wr.data = text_byte;

    if (key_step) begin
      if (!hex_count[0]) begin
        pending_next = nib;
      end else begin
        wr.en   = key_pos < REPORT_P;
        wr.addr = {1'b1, key_pos[4:3]};
        wr.lane = key_pos[2:0];
        wr.data = {pending, nib};
      end
      if (hex_count == HEX_LAST) begin
        rec_done      = 1'b1;
        accepted_next = acc_inc;
        phase_next    = (acc_inc >= KEY_LIMIT) ? PH_STOPPED : PH_SKIP_LINE;
      end else begin
        hex_count_next = hex_count + HXW'(1);
      end
    end

    if (end_of_text) begin
      phase_next     = PH_LINE_START;
      id_count_next  = '0;
      hex_count_next = '0;
      pending_next   = '0;
      accepted_next  = '0;
    end

    wr.en = wr.en && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LINE_START;
      id_count  <= '0;
      hex_count <= '0;
      pending   <= '0;
      accepted  <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      id_count  <= id_count_next;
      hex_count <= hex_count_next;
      pending   <= pending_next;
      accepted  <= accepted_next;
    end
  end

  // readout pipeline: issue, memory read register, output register
  assign s2_load = !out_valid || !out_stall;
  assign s1_free = !s1_valid || s2_load;
  assign issue   = seq_busy && s1_free;
  assign rd_en   = issue && seq_record;

  always_comb begin
    s1_next = '0;
    if (seq_record) begin
      s1_next.kind  = hkrp_pkg::ITEM_RECORD;
      s1_next.slot  = seq_slot;
      s1_next.widx  = seq_word;
      s1_next.idcnt = seq_idcnt;
      s1_next.idlen = seq_idlen;
      s1_next.total = seq_total;
      s1_next.last  = (seq_word == hkrp_pkg::LAST_WORD) && !seq_summary;
    end else begin
      s1_next.kind  = hkrp_pkg::ITEM_SUMMARY;
      s1_next.total = sum_total;
      s1_next.last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_busy    <= 1'b0;
      seq_record  <= 1'b0;
      seq_summary <= 1'b0;
    end else if (accept && (rec_done || end_of_text)) begin
      seq_busy    <= 1'b1;
      seq_record  <= rec_done;
      seq_summary <= end_of_text;
    end else if (issue) begin
      if (seq_record) begin
        if (seq_word == hkrp_pkg::LAST_WORD) begin
          seq_record <= 1'b0;
          seq_busy   <= seq_summary;
        end
      end else begin
        seq_summary <= 1'b0;
        seq_busy    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq_word  <= '0;
      seq_slot  <= accepted[2:0];
      seq_idcnt <= id_cnt_p;
      seq_idlen <= (id_cnt_p > IDLEN_MAX) ? 5'd31 : id_cnt_p[4:0];
      seq_total <= acc_inc;
      sum_total <= rec_done ? acc_inc : accepted;
    end else if (issue && seq_record) begin
      seq_word <= seq_word + 3'd1;
    end
  end

  hkrp_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (seq_word),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1 <= s1_next;
    end
  end

  // bytes beyond the identifier or key read as zero
  always_comb begin
    logic [PW-1:0] pos;
    logic          keep;
    masked = '0;
    for (int b = 0; b < hkrp_pkg::WORD_BYTES; b++) begin
      pos  = {2'b00, s1.widx[1:0], hkrp_pkg::LANE_W'(b)};
      keep = (s1.kind == hkrp_pkg::ITEM_RECORD) &&
             (s1.widx[2] ? (pos < KEY_BYTES_P) : (pos < s1.idcnt));
      masked[b*8 +: 8] = keep ? rd_data[b*8 +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      item_kind   <= s1.kind;
      slot        <= s1.slot;
      word_index  <= s1.widx;
      word_value  <= masked;
      id_length   <= s1.idlen;
      key_total   <= s1.total;
      last_of_run <= s1.last;
    end
  end

  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == hkrp_pkg::ITEM_SUMMARY |-> last_of_run)
    else $error("summary beat without last_of_run");

  a_mid_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == hkrp_pkg::ITEM_RECORD && word_index != hkrp_pkg::LAST_WORD
    |-> !last_of_run)
    else $error("last_of_run on an inner record word");

  a_end_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && end_of_text |=> in_stall)
    else $error("end byte did not hold the input for the summary");

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_total <= KEY_LIMIT)
    else $error("key_total beyond key limit");

endmodule
